// ===== rtl/battery_voltage_gauge_macros.svh =====
// Assertion macros used by the gauge RTL.
`ifndef BATTERY_VOLTAGE_GAUGE_MACROS_SVH
`define BATTERY_VOLTAGE_GAUGE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BVG_ASSERT_SAME(label, antecedent, consequent, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (antecedent) |-> (consequent)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BVG_ASSERT_NEXT(label, antecedent, consequent, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (antecedent) |=> (consequent)) else $error(msg);

`endif

// ===== rtl/bvg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bvg_pkg;

   localparam int AverageDepth = 6;
   localparam int MvWidth      = 13;
   localparam int HystWidth    = 8;
   localparam int PctWidth     = 7;
   localparam int CsrIndexWidth = 3;
   localparam int PointerWidth = $clog2(AverageDepth);
   localparam int SumWidth     = MvWidth + $clog2(AverageDepth);
   localparam int RecipShift   = SumWidth + 4;
   localparam int RecipValue   = ((2 ** RecipShift) + AverageDepth - 1) / AverageDepth;
   localparam int ProdWidth    = SumWidth + RecipShift;

   localparam int PointCount   = 11;
   localparam int SegWidth     = $clog2(PointCount);

   localparam logic [MvWidth-1:0] PctPoints [PointCount] = '{
      13'd3100, 13'd3580, 13'd3660, 13'd3710, 13'd3740, 13'd3770,
      13'd3810, 13'd3870, 13'd3940, 13'd4040, 13'd4150
   };
   localparam logic [PctWidth-1:0] PercentFull = 7'd100;

   localparam logic [CsrIndexWidth-1:0] CsrValidMin  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrValidMax  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrReseedJump = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrFullThr   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrUnderThr  = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CsrHysteresis = 3'd5;

   typedef enum logic [1:0] {
      STATUS_CHARGED  = 2'd0,
      STATUS_CHARGING = 2'd1,
      STATUS_OK       = 2'd2,
      STATUS_LOW      = 2'd3
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/bvg_percent.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bvg_percent (
   input  logic [bvg_pkg::MvWidth-1:0]  average_mv,
   output logic [bvg_pkg::PctWidth-1:0] charge_percent
);
   import bvg_pkg::*;

   localparam int DiffWidth = MvWidth + 4;

   logic [SegWidth-1:0]  above_count;
   logic [SegWidth-1:0]  seg;
   logic [MvWidth-1:0]   lo;
   logic [MvWidth-1:0]   span;
   logic [MvWidth-1:0]   diff;
   logic [DiffWidth-1:0] diff10;
   logic [3:0]           digit;

   always_comb begin
      above_count = '0;
      for (int k = 0; k < PointCount - 1; k++) begin
         above_count = above_count + SegWidth'(average_mv >= PctPoints[k]);
      end
      seg    = (above_count == '0) ? '0 : above_count - 1'b1;
      lo     = PctPoints[seg];
      span   = PctPoints[seg + 1'b1] - lo;
      diff   = average_mv - lo;
      diff10 = DiffWidth'(diff) * DiffWidth'(10);
      digit  = '0;
      for (int j = 1; j < 10; j++) begin
         digit = digit + 4'(diff10 >= DiffWidth'(j) * DiffWidth'(span));
      end
      if (average_mv >= PctPoints[PointCount-1]) begin
         charge_percent = PercentFull;
      end else if (above_count == '0) begin
         charge_percent = '0;
      end else begin
         charge_percent = PctWidth'(seg) * PctWidth'(10) + PctWidth'(digit);
      end
   end

endmodule
`default_nettype wire

// ===== rtl/battery_voltage_gauge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Voltage-based battery state-of-charge gauge.
// The request channel carries an optional voltage sample with the charger
// flags; every accepted item yields exactly one item on the response channel
// with the averaged voltage, a percentage and a charge status.
// Items pass through an input register, a state-update stage and a result
// register, in that order, before their result is offered.
// One item is accepted in every cycle in which req_stall is low; the moving
// average is kept as a running sum, so the state update is combinational.
// When the receiver stalls, the result is held and the stall ripples back
// stage by stage, so req_stall rises only once all three stages are full.
// Synchronous reset empties the pipeline, restores the register defaults and
// clears the average, the seeded flag and the hysteresis flag. The user must
// write threshold registers through the csr_ port while idle; not enforced.
module battery_voltage_gauge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_sample_present,
   input  logic [bvg_pkg::MvWidth-1:0]       req_sample_mv,
   input  logic                              req_power_good,
   input  logic                              req_charge_active,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bvg_pkg::MvWidth-1:0]       rsp_average_mv,
   output logic [bvg_pkg::PctWidth-1:0]      rsp_charge_percent,
   output logic [1:0]                        rsp_battery_status,
   input  logic                              csr_write_enable,
   input  logic [bvg_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [bvg_pkg::MvWidth-1:0]       csr_write_data
);
   import bvg_pkg::*;

   `include "battery_voltage_gauge_macros.svh"

   logic [MvWidth-1:0]   valid_min_ff, valid_max_ff, reseed_jump_ff;
   logic [MvWidth-1:0]   full_thr_ff, under_thr_ff;
   logic [HystWidth-1:0] hysteresis_ff;

   logic                 in_valid_ff, in_present_ff, in_charger_ff;
   logic [MvWidth-1:0]   in_sample_ff;
   logic                 mid_valid_ff;
   logic [MvWidth-1:0]   mid_avg_ff;
   status_type           mid_status_ff;
   logic                 rsp_valid_ff;
   logic [MvWidth-1:0]   rsp_avg_ff;
   logic [PctWidth-1:0]  rsp_pct_ff;
   status_type           rsp_status_ff;

   logic [MvWidth-1:0]      slots_ff [AverageDepth];
   logic [MvWidth-1:0]      slots_in [AverageDepth];
   logic [PointerWidth-1:0] ptr_ff, ptr_in, ptr_next;
   logic                    seeded_ff, seeded_in;
   logic [SumWidth-1:0]     sum_ff, sum_in;
   logic [MvWidth-1:0]      avg_ff, avg_in;
   logic                    hyst_ff, hyst_in;
   status_type              status_in;

   logic                  adv_out, adv_mid, adv_in, move_in;
   logic                  in_window, reseed, upper;
   logic [ProdWidth-1:0]  prod;
   logic [MvWidth-1:0]    thr;
   logic [HystWidth-1:0]  reduce;
   logic [PctWidth-1:0]   pct_in;

   assign adv_out   = !rsp_valid_ff || !rsp_stall;
   assign adv_mid   = !mid_valid_ff || adv_out;
   assign adv_in    = !in_valid_ff || adv_mid;
   assign move_in   = in_valid_ff && adv_mid;
   assign req_stall = !adv_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_min_ff   <= 13'd500;
         valid_max_ff   <= 13'd5000;
         reseed_jump_ff <= 13'd150;
         full_thr_ff    <= 13'd4150;
         under_thr_ff   <= 13'd2800;
         hysteresis_ff  <= 8'd20;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrValidMin:   valid_min_ff   <= csr_write_data;
            CsrValidMax:   valid_max_ff   <= csr_write_data;
            CsrReseedJump: reseed_jump_ff <= csr_write_data;
            CsrFullThr:    full_thr_ff    <= csr_write_data;
            CsrUnderThr:   under_thr_ff   <= csr_write_data;
            CsrHysteresis: hysteresis_ff  <= csr_write_data[HystWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_window = in_present_ff && (in_sample_ff > valid_min_ff)
                  && (in_sample_ff < valid_max_ff);
      reseed    = !seeded_ff || ({1'b0, in_sample_ff} >
                  ({1'b0, avg_ff} + {1'b0, reseed_jump_ff}));
      ptr_next  = (ptr_ff == PointerWidth'(AverageDepth - 1)) ? '0 : ptr_ff + 1'b1;
      slots_in  = slots_ff;
      ptr_in    = ptr_ff;
      seeded_in = seeded_ff;
      sum_in    = sum_ff;
      if (in_window && reseed) begin
         for (int i = 0; i < AverageDepth; i++) begin
            slots_in[i] = in_sample_ff;
         end
         ptr_in    = '0;
         seeded_in = 1'b1;
         sum_in    = SumWidth'(in_sample_ff) * SumWidth'(AverageDepth);
      end else if (in_window) begin
         slots_in[ptr_next] = in_sample_ff;
         ptr_in = ptr_next;
         sum_in = sum_ff - SumWidth'(slots_ff[ptr_next]) + SumWidth'(in_sample_ff);
      end
      prod   = ProdWidth'(sum_in) * ProdWidth'(RecipValue);
      avg_in = prod[RecipShift +: MvWidth];
      reduce = hyst_ff ? hysteresis_ff : '0;
      thr    = in_charger_ff ? full_thr_ff : under_thr_ff;
      // Adding the reduction to the average avoids a negative threshold.
      upper  = ({1'b0, avg_in} + (MvWidth + 1)'(reduce)) >= {1'b0, thr};
      hyst_in = upper;
      if (in_charger_ff) begin
         status_in = upper ? STATUS_CHARGED : STATUS_CHARGING;
      end else begin
         status_in = upper ? STATUS_OK : STATUS_LOW;
      end
   end

   bvg_percent u_percent (
      .average_mv     (mid_avg_ff),
      .charge_percent (pct_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         seeded_ff    <= 1'b0;
         sum_ff       <= '0;
         avg_ff       <= '0;
         hyst_ff      <= 1'b0;
      end else begin
         if (adv_in) begin
            in_valid_ff <= req_valid;
         end
         if (adv_mid) begin
            mid_valid_ff <= in_valid_ff;
         end
         if (adv_out) begin
            rsp_valid_ff <= mid_valid_ff;
         end
         if (move_in) begin
            ptr_ff    <= ptr_in;
            seeded_ff <= seeded_in;
            sum_ff    <= sum_in;
            avg_ff    <= avg_in;
            hyst_ff   <= hyst_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in && req_valid) begin
         in_present_ff <= req_sample_present;
         in_sample_ff  <= req_sample_mv;
         in_charger_ff <= req_power_good || req_charge_active;
      end
      if (move_in) begin
         slots_ff      <= slots_in;
         mid_avg_ff    <= avg_in;
         mid_status_ff <= status_in;
      end
      if (adv_out && mid_valid_ff) begin
         rsp_avg_ff    <= mid_avg_ff;
         rsp_pct_ff    <= pct_in;
         rsp_status_ff <= mid_status_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_average_mv     = rsp_avg_ff;
   assign rsp_charge_percent = rsp_pct_ff;
   assign rsp_battery_status = rsp_status_ff;

   `BVG_ASSERT_SAME(a_stall_needs_full_pipe, req_stall,
      in_valid_ff && mid_valid_ff && rsp_valid_ff, "stall without a full pipeline")
   `BVG_ASSERT_NEXT(a_seeded_sticks, seeded_ff, seeded_ff, "seeded flag cleared")
   `BVG_ASSERT_SAME(a_pointer_in_range, 1'b1,
      ptr_ff < PointerWidth'(AverageDepth), "slot pointer out of range")
   `BVG_ASSERT_SAME(a_percent_in_range, rsp_valid_ff,
      rsp_pct_ff <= PercentFull, "percent above full scale")
   `BVG_ASSERT_SAME(a_unseeded_average_zero, !seeded_ff,
      avg_ff == '0 && sum_ff == '0, "average moved before the first sample")

endmodule
`default_nettype wire
